// File: rtl/json_string_unescape_defines.svh
// Assertion macros for the JSON string unescaper.
// Included by the top level; no other dependencies.
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
// No dependencies.
package jsu_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  localparam int MAX_RESULTS = 4;
  localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [15:0] UTF8_ONE_MAX = 16'h007F;
  localparam logic [15:0] UTF8_TWO_MAX = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  hex_count;
    logic [15:0] code_point;
  } state_t;

  localparam state_t STATE_RESET = '{phase: PH_IDLE, hex_count: 2'd0, code_point: 16'd0};

  // All results caused by one input byte, in delivery order from entry 0.
  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    logic [MAX_RESULTS-1:0][1:0]  kinds;
    logic [MAX_RESULTS-1:0][7:0]  data;
  } bundle_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Hex digit value; bit 4 set when c is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    return v;
  endfunction

endpackage

// File: rtl/jsu_channels.sv
// Valid/ready channel interfaces for the JSON string unescaper.
// No dependencies.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       run_end;

  modport source (output valid, output kind, output out_byte, output run_end, input ready);
  modport sink   (input valid, input kind, input out_byte, input run_end, output ready);
endinterface

// File: rtl/jsu_decode.sv
// Combinational decoder: next parser state and the result bundle for one byte.
// Depends on jsu_pkg.
module jsu_decode (
  input  jsu_pkg::state_t  st,
  input  logic [7:0]       c,
  input  logic             eot,
  output jsu_pkg::state_t  st_next,
  output jsu_pkg::bundle_t bundle
);
  import jsu_pkg::*;

  always_comb begin
    logic        err;
    logic        done;
    logic [1:0]  nd;
    logic [2:0][7:0] dv;
    logic [4:0]  hv;
    logic [15:0] cpn;

    st_next = st;
    err     = 1'b0;
    done    = 1'b0;
    nd      = 2'd0;
    dv      = '0;
    hv      = hex_val(c);
    cpn     = {st.code_point[11:0], hv[3:0]};

    unique case (st.phase)
      PH_IDLE: begin
        if (c == CH_QUOTE) st_next.phase = PH_STR;
        else if (!is_ws(c)) err = 1'b1;
        else if (eot) err = 1'b1;
      end
      PH_STR: begin
        if (c == CH_QUOTE) done = 1'b1;
        else if (c == CH_BSLASH) st_next.phase = PH_ESC;
        else begin
          nd    = 2'd1;
          dv[0] = c;
        end
      end
      PH_ESC: begin
        st_next.phase = PH_STR;
        unique case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: begin nd = 2'd1; dv[0] = c;     end
          CH_B:                          begin nd = 2'd1; dv[0] = CH_BS; end
          CH_F:                          begin nd = 2'd1; dv[0] = CH_FF; end
          CH_N:                          begin nd = 2'd1; dv[0] = CH_LF; end
          CH_R:                          begin nd = 2'd1; dv[0] = CH_CR; end
          CH_T:                          begin nd = 2'd1; dv[0] = CH_TAB; end
          CH_U: begin
            st_next.phase      = PH_HEX;
            st_next.hex_count  = 2'd0;
            st_next.code_point = 16'd0;
          end
          default: err = 1'b1;
        endcase
      end
      PH_HEX: begin
        if (hv[4]) begin
          err = 1'b1;
        end else begin
          st_next.code_point = cpn;
          if (st.hex_count == 2'd3) begin
            st_next.hex_count = 2'd0;
            st_next.phase     = PH_STR;
            if (cpn <= UTF8_ONE_MAX) begin
              nd    = 2'd1;
              dv[0] = cpn[7:0];
            end else if (cpn <= UTF8_TWO_MAX) begin
              nd    = 2'd2;
              dv[0] = UTF8_LEAD2 | {3'b000, cpn[10:6]};
              dv[1] = UTF8_CONT  | {2'b00, cpn[5:0]};
            end else begin
              nd    = 2'd3;
              dv[0] = UTF8_LEAD3 | {4'b0000, cpn[15:12]};
              dv[1] = UTF8_CONT  | {2'b00, cpn[11:6]};
              dv[2] = UTF8_CONT  | {2'b00, cpn[5:0]};
            end
          end else begin
            st_next.hex_count = st.hex_count + 2'd1;
          end
        end
      end
      default: err = 1'b1;
    endcase

    // Text that runs out anywhere but idle leaves the string unterminated.
    if (!done && !err && eot && (st_next.phase != PH_IDLE)) err = 1'b1;

    if (done || err) st_next = STATE_RESET;

    bundle       = '0;
    bundle.count = COUNT_W'(nd) + COUNT_W'(done | err);
    for (int i = 0; i < 3; i++) begin
      if (i < int'(nd)) begin
        bundle.kinds[i] = KIND_DATA;
        bundle.data[i]  = dv[i];
      end
    end
    if (done || err) begin
      bundle.kinds[nd] = done ? KIND_DONE : KIND_ERR;
      bundle.data[nd]  = 8'h00;
    end
  end

endmodule

// File: rtl/json_string_unescape.sv
// Top level of the JSON string unescaper: parser state, result register, serializer.
// Depends on jsu_pkg, jsu_channels (jsu_in_if, jsu_out_if), jsu_decode and the
// assertion macros in json_string_unescape_defines.svh.
//
//   channel  direction  payload                        accepted when
//   text     sink       text_byte, end_of_text         text.valid && text.ready
//   result   source     kind, out_byte, run_end        result.valid && result.ready
//
// A text byte is decoded in the cycle it is accepted, and its zero to four results
// wait in the result register and leave one per cycle while result.ready is high, so a
// stream with at most one result per byte runs at one byte per cycle. A byte with k > 1
// results holds the text channel while the register drains. Reset is synchronous, with
// no clearing pass. A stalled result consumer stalls text as soon as the register holds
// any result, since a new byte is taken only as the last leaves.
`include "json_string_unescape_defines.svh"

module json_string_unescape (
  input logic       clk,
  input logic       rst,
  jsu_in_if.sink    text,
  jsu_out_if.source result
);
  import jsu_pkg::*;

  state_t  st;
  state_t  st_next;
  bundle_t bundle;

  // Result register: remaining count plus the entries still to deliver,
  // with the next one always in entry 0.
  logic [COUNT_W-1:0]          rem;
  logic [MAX_RESULTS-1:0][1:0] kinds;
  logic [MAX_RESULTS-1:0][7:0] data;

  logic load;
  logic take;

  jsu_decode u_decode (
    .st      (st),
    .c       (text.text_byte),
    .eot     (text.end_of_text),
    .st_next (st_next),
    .bundle  (bundle)
  );

  assign take = result.valid && result.ready;
  assign load = text.valid && text.ready;

  // The register can take a new bundle when empty, or when its last entry
  // leaves in this same cycle.
  assign text.ready = (rem == COUNT_W'(0)) || (take && (rem == COUNT_W'(1)));

  assign result.valid    = (rem != COUNT_W'(0));
  assign result.kind     = kinds[0];
  assign result.out_byte = data[0];
  assign result.run_end  = (rem == COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= STATE_RESET;
      rem <= '0;
    end else begin
      if (load) st <= st_next;
      if (load) begin
        rem <= bundle.count;
      end else if (take) begin
        rem <= rem - COUNT_W'(1);
      end
    end
  end

  // Payload side needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      kinds <= bundle.kinds;
      data  <= bundle.data;
    end else if (take) begin
      kinds <= {2'b00, kinds[MAX_RESULTS-1:1]};
      data  <= {8'h00, data[MAX_RESULTS-1:1]};
    end
  end

  // A new byte is only taken over pending results when the last one leaves.
  `JSU_ASSERT_NOW(a_no_overwrite, clk, rst, load && (rem != COUNT_W'(0)), take && (rem == COUNT_W'(1)), "text accepted over pending results")
  // Completion and error always close the run of results for their byte.
  `JSU_ASSERT_NOW(a_tail_last, clk, rst, result.valid && (result.kind != KIND_DATA), result.run_end, "completion or error not last in run")
  // Draining without a load removes exactly one result.
  `JSU_ASSERT_NEXT(a_drain_one, clk, rst, take && !load, rem == $past(rem) - COUNT_W'(1), "result count did not drop by one")

endmodule

// File: sim/json_string_unescape_sb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the JSON string unescaper testbench: a byte-level decoder that
// predicts the result transactions and an in-order checker. Depends on jsu_pkg.
package json_string_unescape_sb_pkg;
  import jsu_pkg::*;

  typedef struct {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       run_end;
  } decoded_result_t;

  // Value of a hex digit in either case; bit 4 flags a byte that is not one.
  function automatic logic [4:0] hex_digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic bit is_json_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  class unescape_scoreboard;
    phase_t          phase;
    logic [1:0]      hex_count;
    logic [15:0]     code_point;
    decoded_result_t expected_results[$];
    int unsigned     failures;
    int unsigned     bytes_noted;
    int unsigned     results_checked;
    int unsigned     strings_completed;
    int unsigned     errors_reported;
    int unsigned     utf8_seen[3];

    function new();
      phase      = PH_IDLE;
      hex_count  = 2'd0;
      code_point = 16'd0;
    endfunction

    function void add_result(kind_t kind, logic [7:0] value);
      decoded_result_t r;
      r.kind     = kind;
      r.out_byte = value;
      r.run_end  = 1'b0;
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void encode_utf8(logic [15:0] cp);
      if (cp <= UTF8_ONE_MAX) begin
        add_result(KIND_DATA, cp[7:0]);
        utf8_seen[0]++;
      end else if (cp <= UTF8_TWO_MAX) begin
        add_result(KIND_DATA, UTF8_LEAD2 | {3'b000, cp[10:6]});
        add_result(KIND_DATA, UTF8_CONT | {2'b00, cp[5:0]});
        utf8_seen[1]++;
      end else begin
        add_result(KIND_DATA, UTF8_LEAD3 | {4'b0000, cp[15:12]});
        add_result(KIND_DATA, UTF8_CONT | {2'b00, cp[11:6]});
        add_result(KIND_DATA, UTF8_CONT | {2'b00, cp[5:0]});
        utf8_seen[2]++;
      end
    endfunction

    // Advance the decoder by one accepted text byte and queue its results.
    function void note_text(logic [7:0] c, logic eot);
      int unsigned queued;
      logic [4:0]  digit;
      bit          done;
      bit          err;
      queued = expected_results.size();
      done   = 1'b0;
      err    = 1'b0;
      bytes_noted++;
      case (phase)
        PH_IDLE: begin
          if (c == CH_QUOTE) phase = PH_STR;
          else if (!is_json_space(c) || eot) err = 1'b1;
        end
        PH_STR: begin
          if (c == CH_QUOTE) done = 1'b1;
          else if (c == CH_BSLASH) phase = PH_ESC;
          else add_result(KIND_DATA, c);
        end
        PH_ESC: begin
          phase = PH_STR;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(KIND_DATA, c);
            CH_B: add_result(KIND_DATA, CH_BS);
            CH_F: add_result(KIND_DATA, CH_FF);
            CH_N: add_result(KIND_DATA, CH_LF);
            CH_R: add_result(KIND_DATA, CH_CR);
            CH_T: add_result(KIND_DATA, CH_TAB);
            CH_U: begin
              phase      = PH_HEX;
              hex_count  = 2'd0;
              code_point = 16'd0;
            end
            default: err = 1'b1;
          endcase
        end
        default: begin
          digit = hex_digit_value(c);
          if (digit[4]) begin
            err = 1'b1;
          end else begin
            code_point = {code_point[11:0], digit[3:0]};
            if (hex_count == 2'd3) begin
              hex_count = 2'd0;
              phase     = PH_STR;
              encode_utf8(code_point);
            end else begin
              hex_count = hex_count + 2'd1;
            end
          end
        end
      endcase
      if (!done && !err && eot && phase != PH_IDLE) err = 1'b1;
      if (done) begin
        add_result(KIND_DONE, 8'h00);
        strings_completed++;
      end else if (err) begin
        add_result(KIND_ERR, 8'h00);
        errors_reported++;
      end
      if (done || err) begin
        phase      = PH_IDLE;
        hex_count  = 2'd0;
        code_point = 16'd0;
      end
      if (expected_results.size() > queued)
        expected_results[expected_results.size() - 1].run_end = 1'b1;
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] value, logic run_end);
      decoded_result_t want;
      results_checked++;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected result kind=%0d byte=%02h run_end=%0b",
                   kind, value, run_end);
        return;
      end
      want = expected_results.pop_front();
      if (kind !== want.kind || value !== want.out_byte || run_end !== want.run_end) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: result %0d: expected kind=%0d byte=%02h run_end=%0b, got %0d %02h %0b",
                   results_checked, want.kind, want.out_byte, want.run_end,
                   kind, value, run_end);
      end
    endfunction

    function void check_leftovers();
      if (expected_results.size() != 0) begin
        failures += expected_results.size();
        $display("ERROR: %0d expected results never arrived", expected_results.size());
      end
    endfunction
  endclass

endpackage

// File: sim/json_string_unescape_tb.sv
`timescale 1ns / 1ps
// Testbench for json_string_unescape: directed and random JSON text, checked
// against the scoreboard in json_string_unescape_sb_pkg. Depends on jsu_pkg and
// the jsu_in_if / jsu_out_if channel interfaces.
module json_string_unescape_tb;
  import jsu_pkg::*;
  import json_string_unescape_sb_pkg::*;

  typedef struct {
    logic [7:0] text_byte;
    logic       eot;
  } text_item_t;

  // Amount of random text after the directed part.
  localparam int RANDOM_ITEMS = 195;
  // Percentage of cycles in which either side idles.
  localparam int IDLE_PERCENT = 28;
  // The receiver stops taking results for a long stretch once this many text
  // transactions have gone through, so the result register fills up.
  localparam int HOLD_AFTER   = 60;
  localparam int HOLD_LENGTH  = 120;
  // Before this item the sender waits for every outstanding result.
  localparam int PAUSE_INDEX  = 140;
  // Items in this window go back to back on both sides.
  localparam int STEADY_FIRST = 170;
  localparam int STEADY_LAST  = 215;
  // The block is one register deep, so this drain margin covers any stray result.
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] UPPER_A    = 8'h41;

  logic clk;
  logic rst;

  jsu_in_if  text_ch ();
  jsu_out_if result_ch ();

  json_string_unescape u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  unescape_scoreboard sb = new();

  text_item_t  text_stream[$];
  int unsigned text_accepted = 0;
  bit          steady_run = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction. The whole text stream is built before reset is
  // released; the driver below then plays it out with random gaps.
  // ---------------------------------------------------------------------------

  function automatic void push_byte(logic [7:0] b, logic eot = 1'b0);
    text_item_t item;
    item.text_byte = b;
    item.eot       = eot;
    text_stream.insert(text_stream.size(), item);
  endfunction

  // Hex digit as text, with letters in a random case.
  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return DIGIT_ZERO + {4'h0, v};
    return ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + {4'h0, v} - 8'd10;
  endfunction

  function automatic void push_unicode(logic [15:0] cp);
    push_byte(CH_BSLASH);
    push_byte(CH_U);
    for (int i = 3; i >= 0; i--) push_byte(hex_char(cp[i*4 +: 4]));
  endfunction

  // Spread code points evenly over the one, two and three byte encodings.
  function automatic logic [15:0] random_code_point();
    case ($urandom_range(0, 2))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      default: return 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [7:0] random_space();
    if ($urandom_range(0, 5) == 0) return CH_SPACE;
    return CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] random_escape();
    case ($urandom_range(0, 7))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SLASH;
      3:       return CH_B;
      4:       return CH_F;
      5:       return CH_N;
      6:       return CH_R;
      default: return CH_T;
    endcase
  endfunction

  // String body: plain bytes (anything but a quote or a backslash), the short
  // escapes, and unicode escapes.
  function automatic void push_content(int pieces);
    logic [7:0] b;
    int         pick;
    repeat (pieces) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        push_byte(b);
      end else if (pick < 75) begin
        push_byte(CH_BSLASH);
        push_byte(random_escape());
      end else begin
        push_unicode(random_code_point());
      end
    end
  endfunction

  // A string with optional leading whitespace. A broken one ends in a bad
  // escape, a bad hex digit, or the end of the text before the closing quote.
  function automatic void push_string(bit broken);
    logic [7:0] b;
    logic [4:0] digit;
    repeat ($urandom_range(0, 2)) push_byte(random_space());
    push_byte(CH_QUOTE);
    push_content($urandom_range(0, 6));
    if (!broken) begin
      push_byte(CH_QUOTE, $urandom_range(0, 9) == 0);
      return;
    end
    case ($urandom_range(0, 2))
      0: begin
        push_byte(CH_BSLASH);
        do b = 8'($urandom_range(0, 255));
        while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        push_byte(b);
      end
      1: begin
        push_byte(CH_BSLASH);
        push_byte(CH_U);
        repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom_range(0, 15))));
        do begin
          b     = 8'($urandom_range(0, 255));
          digit = hex_digit_value(b);
        end while (!digit[4]);
        push_byte(b);
      end
      default: begin
        // The text may run out on the opening quote or the last body byte, right after a
        // backslash, or part way through a unicode escape.
        case ($urandom_range(0, 2))
          1: push_byte(CH_BSLASH);
          2: begin
            push_byte(CH_BSLASH);
            push_byte(CH_U);
            repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom_range(0, 15))));
          end
          default: ;
        endcase
        text_stream[text_stream.size() - 1].eot = 1'b1;
      end
    endcase
  endfunction

  // Arbitrary bytes, now and then flagged as the end of the text.
  function automatic void push_noise();
    repeat ($urandom_range(1, 4))
      push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endfunction

  function automatic void build_stimulus();
    int directed_count;
    int pick;
    // Whitespace before a string, byte extremes inside it, and the widest
    // unicode escape with mixed-case digits.
    push_byte(8'h0B);
    push_byte(CH_CR);
    push_byte(CH_QUOTE);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_BSLASH);
    push_byte(CH_U);
    push_byte("F");
    push_byte("f");
    push_byte("F");
    push_byte("F");
    push_byte(CH_QUOTE);
    // A stray byte while idle, and text that ends on whitespace alone.
    push_byte("X");
    push_byte(CH_SPACE, 1'b1);
    // An unknown escape letter.
    push_byte(CH_QUOTE);
    push_byte(CH_BSLASH);
    push_byte("q");
    // A bad first hex digit.
    push_byte(CH_QUOTE);
    push_byte(CH_BSLASH);
    push_byte(CH_U);
    push_byte("g");
    // Text that ends inside the string, after a data byte.
    push_byte(CH_QUOTE);
    push_byte("a", 1'b1);
    directed_count = text_stream.size();

    // Mostly well-formed strings, the rest broken strings and noise.
    while (text_stream.size() < directed_count + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) push_string(1'b0);
      else if (pick < 88) push_string(1'b1);
      else push_noise();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Each call offers one text transaction, idling first at random,
  // and hands the byte to the scoreboard once it has been accepted.
  // ---------------------------------------------------------------------------

  task automatic send_text(text_item_t item);
    while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_byte   <= item.text_byte;
    text_ch.end_of_text <= item.eot;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    sb.note_text(item.text_byte, item.eot);
    text_accepted++;
  endtask

  initial begin
    rst                 <= 1'b1;
    text_ch.valid       <= 1'b0;
    text_ch.text_byte   <= 8'h00;
    text_ch.end_of_text <= 1'b0;
    build_stimulus();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (text_stream[i]) begin
      // Once in the run, let the block drain completely before going on.
      if (i == PAUSE_INDEX) begin
        text_ch.valid <= 1'b0;
        do @(posedge clk);
        while (sb.expected_results.size() != 0);
      end
      steady_run = (i >= STEADY_FIRST) && (i < STEADY_LAST);
      send_text(text_stream[i]);
    end
    text_ch.valid <= 1'b0;
    steady_run = 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftovers();

    $display("Run fed %0d text transactions and checked %0d result transactions:",
             sb.bytes_noted, sb.results_checked);
    $display("%0d strings completed, %0d errors, unicode escapes of 1/2/3 bytes: %0d/%0d/%0d",
             sb.strings_completed, sb.errors_reported,
             sb.utf8_seen[0], sb.utf8_seen[1], sb.utf8_seen[2]);
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures", sb.failures);
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver. Results are sampled at the clock edge at which they are taken.
  // Ready is dropped at random, except in the steady window, and held low for
  // one long stretch while the sender keeps offering text.
  // ---------------------------------------------------------------------------

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.kind, result_ch.out_byte, result_ch.run_end);
      if (!hold_done && text_accepted >= HOLD_AFTER) begin
        hold_done   = 1'b1;
        hold_cycles = HOLD_LENGTH;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("Timeout waiting for the block");
    $display("FAILURE");
    $finish;
  end

endmodule
